/* src/ecc_pkg.sv */
// ----------------------------------------------------------------------------
// ecc_pkg: shared types and codes of the charge controller
// Field widths, request, pilot, relay, status and register codes, and the
// structs that carry the controller state and the commands of one word.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Field widths
  localparam int ReqW    = 2;
  localparam int VehW    = 3;
  localparam int DeltaW  = 16;
  localparam int LimReqW = 11;
  localparam int AmpsW   = 10;
  localparam int TimerW  = 20;
  localparam int PilotW  = 2;
  localparam int RelayW  = 2;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 20;

  // Default minimum current (MIN_AMPS), tenths of an ampere
  localparam int MinAmpsDefault = 60;

  // Value of max_current after reset; the current limit starts there too
  localparam logic [AmpsW-1:0] MaxCurrentReset = 10'd320;

  // Request codes
  localparam logic [ReqW-1:0] REQ_TICK  = 2'd0;
  localparam logic [ReqW-1:0] REQ_START = 2'd1;
  localparam logic [ReqW-1:0] REQ_STOP  = 2'd2;
  localparam logic [ReqW-1:0] REQ_LIMIT = 2'd3;

  // Vehicle states sensed on the pilot
  localparam logic [VehW-1:0] VS_A        = 3'd0;
  localparam logic [VehW-1:0] VS_B        = 3'd1;
  localparam logic [VehW-1:0] VS_C        = 3'd2;
  localparam logic [VehW-1:0] VS_D        = 3'd3;
  localparam logic [VehW-1:0] VS_NO_POWER = 3'd4;
  localparam logic [VehW-1:0] VS_ERROR    = 3'd5;

  // Pilot commands
  localparam logic [PilotW-1:0] PILOT_NONE    = 2'd0;
  localparam logic [PilotW-1:0] PILOT_STANDBY = 2'd1;
  localparam logic [PilotW-1:0] PILOT_PWM     = 2'd2;

  // Relay commands
  localparam logic [RelayW-1:0] RELAY_NONE     = 2'd0;
  localparam logic [RelayW-1:0] RELAY_OPEN     = 2'd1;
  localparam logic [RelayW-1:0] RELAY_CLOSE    = 2'd2;
  localparam logic [RelayW-1:0] RELAY_OPEN_NOW = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_DONE         = 3'd0;
  localparam logic [StatusW-1:0] ST_LOCKED_OUT   = 3'd1;
  localparam logic [StatusW-1:0] ST_ALREADY_ON   = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_READY    = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_CHARGING = 3'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_CURRENT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RESUME_DELAY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_LOW    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_NOW     = 2'd3;

  typedef struct packed {
    logic              charging;
    logic              lockout;
    logic              paused;
    logic [VehW-1:0]   vehicle_now;
    logic [VehW-1:0]   vehicle_managed;
    logic [AmpsW-1:0]  limit_now;
    logic [TimerW-1:0] pause_timer;
  } ecc_state_t;

  typedef struct packed {
    logic [PilotW-1:0]  pilot;
    logic [AmpsW-1:0]   amps;
    logic [RelayW-1:0]  relay;
    logic [StatusW-1:0] status;
  } ecc_cmd_t;

  typedef struct packed {
    ecc_state_t st;
    ecc_cmd_t   cmd;
  } ecc_work_t;

endpackage

/* src/ecc_if.sv */
// ----------------------------------------------------------------------------
// ecc channel interfaces
// Valid/ready channels of the charge controller: request words, result
// words and configuration writes.
// ----------------------------------------------------------------------------
interface ecc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecc_pkg::ReqW-1:0]             req_type;
  logic [ecc_pkg::VehW-1:0]             vehicle_state;
  logic [ecc_pkg::DeltaW-1:0]           delta_ms;
  logic signed [ecc_pkg::LimReqW-1:0]   limit_request;

  modport source (output valid, req_type, vehicle_state, delta_ms, limit_request,
                  input ready);
  modport sink (input valid, req_type, vehicle_state, delta_ms, limit_request,
                output ready);
endinterface

interface ecc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ecc_pkg::PilotW-1:0]     pilot_cmd;
  logic [ecc_pkg::AmpsW-1:0]      pilot_amps;
  logic [ecc_pkg::RelayW-1:0]     relay_cmd;
  logic                           charging;
  logic                           lockout;
  logic                           paused;
  logic [ecc_pkg::StatusW-1:0]    status;

  modport source (output valid, pilot_cmd, pilot_amps, relay_cmd, charging, lockout,
                  paused, status, input ready);
  modport sink (input valid, pilot_cmd, pilot_amps, relay_cmd, charging, lockout,
                paused, status, output ready);
endinterface

interface ecc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ecc_pkg::CfgIdxW-1:0]   index;
  logic [ecc_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/evse_charge_controller.sv */
// ----------------------------------------------------------------------------
// evse_charge_controller: pilot and relay controller of a charging station
// Tracks the vehicle state, session, error lockout, current limit and the
// low-limit pause, and answers each request word with one result word.
// ----------------------------------------------------------------------------
// Each request word (a tick with the sensed vehicle state and elapsed
// milliseconds, a start, a stop, or a new current limit) gives exactly one
// result word carrying the pilot command, the relay command, the session,
// lockout and pause flags after the word, and a status code. A word is
// taken into an input register, handled in one pass of logic against the
// controller state, and its result lands in an output register, and one
// word is accepted every cycle while the result side keeps up. The rate is
// set by the update of the controller state, which the next word needs. The
// block comes out of reset locked out; a disconnect (vehicle state A) clears
// the lockout. Configuration writes are always taken and must only come
// while the block is idle.
// ----------------------------------------------------------------------------
module evse_charge_controller #(
  parameter int MIN_AMPS = ecc_pkg::MinAmpsDefault
) (
  input  logic      clk,
  input  logic      rst,
  ecc_req_if.sink   req,
  ecc_rsp_if.source rsp,
  ecc_cfg_if.sink   cfg
);

  localparam logic [ecc_pkg::AmpsW-1:0] MinAmps = ecc_pkg::AmpsW'(MIN_AMPS);
  localparam logic [ecc_pkg::TimerW-1:0] TimerMax = '1;

  // Configuration registers.
  logic [ecc_pkg::AmpsW-1:0]  max_current;
  logic [ecc_pkg::TimerW-1:0] resume_delay_ms;
  logic                       pause_at_low_limit;
  logic                       open_relay_now_at_pause;

  // Input register stage.
  logic                                 in_valid;
  logic [ecc_pkg::ReqW-1:0]             in_req_type;
  logic [ecc_pkg::VehW-1:0]             in_vehicle_state;
  logic [ecc_pkg::DeltaW-1:0]           in_delta_ms;
  logic signed [ecc_pkg::LimReqW-1:0]   in_limit_request;

  // Controller state and result register.
  ecc_pkg::ecc_state_t state;
  ecc_pkg::ecc_state_t state_next;
  ecc_pkg::ecc_cmd_t   cmd_next;
  ecc_pkg::ecc_cmd_t   result;
  logic                out_valid;
  logic                advance;

  // The input word moves on whenever the result register is free or is
  // being emptied this cycle, so the input side only stalls on output
  // backpressure.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_current             <= ecc_pkg::MaxCurrentReset;
      resume_delay_ms         <= '0;
      pause_at_low_limit      <= 1'b0;
      open_relay_now_at_pause <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ecc_pkg::CFG_MAX_CURRENT:  max_current <= cfg.data[ecc_pkg::AmpsW-1:0];
        ecc_pkg::CFG_RESUME_DELAY: resume_delay_ms <= cfg.data[ecc_pkg::TimerW-1:0];
        ecc_pkg::CFG_PAUSE_LOW:    pause_at_low_limit <= cfg.data[0];
        ecc_pkg::CFG_OPEN_NOW:     open_relay_now_at_pause <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type      <= req.req_type;
      in_vehicle_state <= req.vehicle_state;
      in_delta_ms      <= req.delta_ms;
      in_limit_request <= req.limit_request;
    end
  end

  // Vehicle states in which the pilot may advertise current.
  function automatic logic vehicle_ok(input logic [ecc_pkg::VehW-1:0] v);
    return (v == ecc_pkg::VS_B) || (v == ecc_pkg::VS_C) || (v == ecc_pkg::VS_D);
  endfunction

  function automatic ecc_pkg::ecc_work_t pilot_pwm(input ecc_pkg::ecc_work_t w,
                                                   input logic [ecc_pkg::AmpsW-1:0] a);
    ecc_pkg::ecc_work_t r;
    r = w;
    r.cmd.pilot = ecc_pkg::PILOT_PWM;
    r.cmd.amps  = a;
    return r;
  endfunction

  function automatic ecc_pkg::ecc_work_t pilot_standby(input ecc_pkg::ecc_work_t w);
    ecc_pkg::ecc_work_t r;
    r = w;
    r.cmd.pilot = ecc_pkg::PILOT_STANDBY;
    r.cmd.amps  = '0;
    return r;
  endfunction

  // Ends a session: the relay always opens at once, and the status tells
  // whether a session was running.
  function automatic ecc_pkg::ecc_work_t do_stop(input ecc_pkg::ecc_work_t w);
    ecc_pkg::ecc_work_t r;
    r = w;
    r.cmd.relay = ecc_pkg::RELAY_OPEN_NOW;
    if (!r.st.charging) begin
      r.cmd.status = ecc_pkg::ST_NOT_CHARGING;
    end else begin
      r.st.charging = 1'b0;
      r.cmd.status  = ecc_pkg::ST_DONE;
    end
    return r;
  endfunction

  // Advertises the limit, pauses or throttles below the minimum, or with no
  // ready vehicle goes to standby. A pause holds until the cooldown runs out.
  function automatic ecc_pkg::ecc_work_t apply_limit(input ecc_pkg::ecc_work_t w);
    ecc_pkg::ecc_work_t r;
    logic               hold;
    r    = w;
    hold = 1'b0;
    if (vehicle_ok(r.st.vehicle_now)) begin
      if (r.st.limit_now >= MinAmps) begin
        if (r.st.paused) begin
          if (r.st.pause_timer >= resume_delay_ms) begin
            r = pilot_pwm(r, r.st.limit_now);
            r.st.paused = 1'b0;
          end else begin
            hold = 1'b1;
          end
        end else begin
          r = pilot_pwm(r, r.st.limit_now);
        end
        if (!hold) begin
          if (r.st.charging && (r.st.vehicle_now == ecc_pkg::VS_C ||
                                r.st.vehicle_now == ecc_pkg::VS_D)) begin
            r.cmd.relay = ecc_pkg::RELAY_CLOSE;
          end else begin
            r.cmd.relay = ecc_pkg::RELAY_OPEN;
          end
        end
      end else if (pause_at_low_limit) begin
        r = pilot_pwm(r, r.st.limit_now);
        r.cmd.relay = open_relay_now_at_pause ? ecc_pkg::RELAY_OPEN_NOW
                                              : ecc_pkg::RELAY_OPEN;
        if (!r.st.paused) begin
          r.st.paused      = 1'b1;
          r.st.pause_timer = '0;
        end
      end else begin
        r = pilot_pwm(r, r.st.limit_now);
        r.st.paused = 1'b0;
      end
    end else begin
      r.cmd.relay = ecc_pkg::RELAY_OPEN;
      r = pilot_standby(r);
      r.st.paused = 1'b0;
    end
    return r;
  endfunction

  // Reacts to a new vehicle state (lockout on error or no power, release on
  // disconnect) and then drives pilot and relay for the present state.
  function automatic ecc_pkg::ecc_work_t manage(input ecc_pkg::ecc_work_t w);
    ecc_pkg::ecc_work_t r;
    r = w;
    if (r.st.vehicle_now != r.st.vehicle_managed) begin
      r.st.vehicle_managed = r.st.vehicle_now;
      if (r.st.vehicle_now == ecc_pkg::VS_NO_POWER || r.st.vehicle_now == ecc_pkg::VS_ERROR) begin
        if (!r.st.lockout) begin
          r.st.lockout = 1'b1;
          if (r.st.charging) begin
            r = do_stop(r);
          end
        end
      end else if (r.st.vehicle_now == ecc_pkg::VS_A && r.st.lockout) begin
        r.st.lockout = 1'b0;
      end
    end
    case (r.st.vehicle_now) inside
      ecc_pkg::VS_B: begin
        if (!r.st.charging) begin
          r = pilot_pwm(r, MinAmps);
        end
        r.cmd.relay = ecc_pkg::RELAY_OPEN;
      end
      ecc_pkg::VS_C, ecc_pkg::VS_D: begin
        if (r.st.charging) begin
          r = pilot_pwm(r, r.st.limit_now);
          r.cmd.relay = ecc_pkg::RELAY_CLOSE;
        end else begin
          r = pilot_pwm(r, MinAmps);
          r.cmd.relay = ecc_pkg::RELAY_OPEN;
        end
      end
      ecc_pkg::VS_ERROR: begin
        r = pilot_standby(r);
        r.cmd.relay = ecc_pkg::RELAY_OPEN_NOW;
      end
      default: begin
        r = pilot_standby(r);
        r.cmd.relay = ecc_pkg::RELAY_OPEN;
      end
    endcase
    return r;
  endfunction

  // One pass over the word in the input register.
  always_comb begin
    ecc_pkg::ecc_work_t          w;
    logic [ecc_pkg::TimerW:0]    tsum;
    logic [ecc_pkg::AmpsW-1:0]   lim;
    w.st  = state;
    w.cmd = '0;
    tsum  = '0;
    lim   = '0;
    case (in_req_type)
      ecc_pkg::REQ_TICK: begin
        // The pause timer runs first and saturates instead of wrapping.
        if (w.st.paused) begin
          tsum = {1'b0, w.st.pause_timer} + (ecc_pkg::TimerW + 1)'(in_delta_ms);
          w.st.pause_timer = tsum[ecc_pkg::TimerW] ? TimerMax : tsum[ecc_pkg::TimerW-1:0];
        end
        if (in_vehicle_state != w.st.vehicle_now) begin
          w.st.vehicle_now = in_vehicle_state;
          if (!vehicle_ok(w.st.vehicle_now) && w.st.charging) begin
            w = do_stop(w);
          end
          w = apply_limit(w);
        end
        w = manage(w);
        if (w.st.paused && w.st.limit_now >= MinAmps &&
            w.st.pause_timer >= resume_delay_ms) begin
          w = apply_limit(w);
        end
        w.cmd.status = ecc_pkg::ST_DONE;
      end
      ecc_pkg::REQ_START: begin
        if (w.st.lockout) begin
          w.cmd.status = ecc_pkg::ST_LOCKED_OUT;
        end else if (w.st.charging) begin
          w.cmd.status = ecc_pkg::ST_ALREADY_ON;
        end else if (!vehicle_ok(w.st.vehicle_now)) begin
          w.cmd.status = ecc_pkg::ST_NOT_READY;
        end else begin
          w.st.charging = 1'b1;
          w = apply_limit(w);
          w.cmd.status = ecc_pkg::ST_DONE;
        end
      end
      ecc_pkg::REQ_STOP: begin
        w = do_stop(w);
      end
      default: begin
        // New limit: negative requests give zero, the top clamps to
        // max_current, and only a real change is applied.
        lim = in_limit_request[ecc_pkg::LimReqW-1] ? '0
                                                   : in_limit_request[ecc_pkg::AmpsW-1:0];
        if (lim > max_current) begin
          lim = max_current;
        end
        if (lim != w.st.limit_now) begin
          w.st.limit_now = lim;
          w = apply_limit(w);
        end
        w.cmd.status = ecc_pkg::ST_DONE;
      end
    endcase
    state_next = w.st;
    cmd_next   = w.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.charging        <= 1'b0;
      state.lockout         <= 1'b1;
      state.paused          <= 1'b0;
      state.vehicle_now     <= ecc_pkg::VS_A;
      state.vehicle_managed <= ecc_pkg::VS_A;
      state.limit_now       <= ecc_pkg::MaxCurrentReset;
      state.pause_timer     <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The flags in the result word are the state after the word, which is
  // exactly what the state register holds once the word has gone through.
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= cmd_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pilot_cmd  = result.pilot;
  assign rsp.pilot_amps = result.amps;
  assign rsp.relay_cmd  = result.relay;
  assign rsp.status     = result.status;
  assign rsp.charging   = state.charging;
  assign rsp.lockout    = state.lockout;
  assign rsp.paused     = state.paused;

  // A session never runs while the lockout is set: entering error or no
  // power ends the session before the lockout is raised.
  assert property (@(posedge clk) disable iff (rst) !(state.charging && state.lockout))
    else $error("session active while locked out");

  // A pause only exists while the vehicle can take current.
  assert property (@(posedge clk) disable iff (rst)
                   state.paused |-> vehicle_ok(state.vehicle_now))
    else $error("pause held with vehicle not ready");

  // The relay is only ever closed for a running session.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && result.relay == ecc_pkg::RELAY_CLOSE) |-> state.charging)
    else $error("relay closed without a session");

  // Current is only advertised with a PWM pilot.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && result.pilot != ecc_pkg::PILOT_PWM) |-> result.amps == '0)
    else $error("amps reported without PWM pilot");

  // Reset leaves the block locked out with no session.
  assert property (@(posedge clk) $past(rst) && !rst |-> state.lockout && !state.charging)
    else $error("not locked out after reset");

endmodule
